>>> rtl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define HGFT_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define HGFT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/hgft_pkg.sv
// Package: types, constants and tables of the gait foot trajectory core.
`timescale 1ns / 1ps
package hgft_pkg;

   localparam int LEG_COUNT   = 6;
   localparam logic [2:0] LEG_LAST = 3'(LEG_COUNT - 1);
   localparam int DIV_STEPS   = 16;
   localparam int FRONT_STEPS = 8;
   localparam logic [2:0] FRONT_CYCLES_M1 = 3'd5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_TRIPOD = 2'd0;
   localparam logic [1:0] MODE_WAVE   = 2'd1;
   localparam logic [1:0] MODE_RIPPLE = 2'd2;

   localparam logic [2:0] CSR_GAIT_MODE = 3'd0;
   localparam logic [2:0] CSR_PERIOD    = 3'd1;
   localparam logic [2:0] CSR_DUTY      = 3'd2;
   localparam logic [2:0] CSR_STRIDE    = 3'd3;
   localparam logic [2:0] CSR_LIFT      = 3'd4;

   localparam logic [15:0] WAVE_DUTY = 16'd55706;
   localparam logic [12:0] WAVE_LIFT = 13'd640;
   localparam logic signed [15:0] STAND_Z = -16'sd1600;

   typedef struct packed {
      logic [1:0]  gait_mode;
      logic [15:0] cycle_period;
      logic [15:0] duty_fraction;
      logic [12:0] step_len;
      logic [12:0] lift_height;
   } cfg_type;

   // One request after the front part: phase, gait settings and stride vector.
   typedef struct packed {
      logic [15:0]        gphase;
      logic [1:0]         mode;
      logic [15:0]        duty;
      logic [12:0]        lift;
      logic signed [44:0] sx;
      logic signed [44:0] sy;
   } qent_type;

   // Per-leg payload traveling down the back pipeline.
   typedef struct packed {
      logic [2:0]         leg;
      logic               last;
      logic               swing;
      logic [12:0]        lift;
      logic signed [44:0] sx;
      logic signed [44:0] sy;
   } leg_pl_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_BUSY,
      FR_DONE
   } front_state_type;

   function automatic logic [15:0] quarter_sine(input logic [6:0] k);
      logic [15:0] v;
      case (k)
         7'd0: v = 16'd0;       7'd1: v = 16'd402;     7'd2: v = 16'd804;
         7'd3: v = 16'd1205;    7'd4: v = 16'd1606;    7'd5: v = 16'd2006;
         7'd6: v = 16'd2404;    7'd7: v = 16'd2801;    7'd8: v = 16'd3196;
         7'd9: v = 16'd3590;    7'd10: v = 16'd3981;   7'd11: v = 16'd4370;
         7'd12: v = 16'd4756;   7'd13: v = 16'd5139;   7'd14: v = 16'd5520;
         7'd15: v = 16'd5897;   7'd16: v = 16'd6270;   7'd17: v = 16'd6639;
         7'd18: v = 16'd7005;   7'd19: v = 16'd7366;   7'd20: v = 16'd7723;
         7'd21: v = 16'd8076;   7'd22: v = 16'd8423;   7'd23: v = 16'd8765;
         7'd24: v = 16'd9102;   7'd25: v = 16'd9434;   7'd26: v = 16'd9760;
         7'd27: v = 16'd10080;  7'd28: v = 16'd10394;  7'd29: v = 16'd10702;
         7'd30: v = 16'd11003;  7'd31: v = 16'd11297;  7'd32: v = 16'd11585;
         7'd33: v = 16'd11866;  7'd34: v = 16'd12140;  7'd35: v = 16'd12406;
         7'd36: v = 16'd12665;  7'd37: v = 16'd12916;  7'd38: v = 16'd13160;
         7'd39: v = 16'd13395;  7'd40: v = 16'd13623;  7'd41: v = 16'd13842;
         7'd42: v = 16'd14053;  7'd43: v = 16'd14256;  7'd44: v = 16'd14449;
         7'd45: v = 16'd14635;  7'd46: v = 16'd14811;  7'd47: v = 16'd14978;
         7'd48: v = 16'd15137;  7'd49: v = 16'd15286;  7'd50: v = 16'd15426;
         7'd51: v = 16'd15557;  7'd52: v = 16'd15679;  7'd53: v = 16'd15791;
         7'd54: v = 16'd15893;  7'd55: v = 16'd15986;  7'd56: v = 16'd16069;
         7'd57: v = 16'd16143;  7'd58: v = 16'd16207;  7'd59: v = 16'd16261;
         7'd60: v = 16'd16305;  7'd61: v = 16'd16340;  7'd62: v = 16'd16364;
         7'd63: v = 16'd16379;  7'd64: v = 16'd16384;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // Full-wave sine in Q2.14 from an 8-bit angle.
   function automatic logic signed [15:0] sine_of(input logic [7:0] idx);
      logic [15:0] v;
      v = idx[6] ? quarter_sine(7'd64 - {1'b0, idx[5:0]}) : quarter_sine({1'b0, idx[5:0]});
      return idx[7] ? -$signed(v) : $signed(v);
   endfunction

   function automatic logic [15:0] leg_phase(input logic [1:0] mode,
                                             input logic [2:0] leg);
      logic [15:0] v;
      case ({mode, leg})
         {MODE_WAVE, 3'd1}:   v = 16'd32768;
         {MODE_WAVE, 3'd2}:   v = 16'd13107;
         {MODE_WAVE, 3'd3}:   v = 16'd45875;
         {MODE_WAVE, 3'd4}:   v = 16'd26214;
         {MODE_WAVE, 3'd5}:   v = 16'd58982;
         {MODE_RIPPLE, 3'd1}: v = 16'd32768;
         {MODE_RIPPLE, 3'd2}: v = 16'd21627;
         {MODE_RIPPLE, 3'd3}: v = 16'd54395;
         {MODE_RIPPLE, 3'd4}: v = 16'd43909;
         {MODE_RIPPLE, 3'd5}: v = 16'd11141;
         {MODE_TRIPOD, 3'd1}: v = 16'd32768;
         {MODE_TRIPOD, 3'd3}: v = 16'd32768;
         {MODE_TRIPOD, 3'd5}: v = 16'd32768;
         default:             v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] stand_x(input logic [2:0] leg);
      logic signed [15:0] v;
      case (leg)
         3'd0, 3'd3: v = 16'sd1600;
         3'd2, 3'd5: v = -16'sd1600;
         default:    v = 16'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] stand_y(input logic [2:0] leg);
      logic signed [15:0] v;
      case (leg)
         3'd0, 3'd2: v = 16'sd1600;
         3'd1:       v = 16'sd1920;
         3'd3, 3'd5: v = -16'sd1600;
         3'd4:       v = -16'sd1920;
         default:    v = 16'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/hgft_front.sv
// Front part: accepts a request, finds the cycle phase and the stride vector.
`timescale 1ns / 1ps
module hgft_front (
   input  logic                clock,
   input  logic                reset,
   input  hgft_pkg::cfg_type   cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_time_tick,
   input  logic [15:0]         req_heading,
   input  logic [15:0]         req_speed_scale,
   output logic                push_valid,
   input  logic                push_ready,
   output hgft_pkg::qent_type  push_entry
);
   import hgft_pkg::*;

   front_state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [47:0] tsh_ff, tsh_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] qacc_ff, qacc_in;
   logic [7:0]  idx_ff;
   logic [15:0] spd_ff;
   logic [28:0] len_ff;
   logic signed [44:0] sx_ff, sy_ff;
   logic [15:0] per;
   logic accept;
   logic signed [45:0] px, py;
   logic [1:0]  mode;

   assign per    = (cfg.cycle_period == 16'd0) ? 16'd1 : cfg.cycle_period;
   assign accept = req_valid && req_ready;
   assign mode   = (cfg.gait_mode > MODE_RIPPLE) ? MODE_TRIPOD : cfg.gait_mode;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: if (req_valid) state_in = FR_BUSY;
         FR_BUSY: if (cnt_ff == FRONT_CYCLES_M1) state_in = FR_DONE;
         FR_DONE: begin
            if (push_ready) state_in = req_valid ? FR_BUSY : FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         FR_IDLE: req_ready = 1'b1;
         FR_BUSY: req_ready = 1'b0;
         FR_DONE: begin
            push_valid = 1'b1;
            req_ready  = push_ready;
         end
         default: req_ready = 1'b0;
      endcase
   end

   // Eight restoring steps of (time << 16) / period per cycle
   always_comb begin
      logic [16:0] sh;
      logic [15:0] r;
      logic [15:0] qa;
      logic [47:0] tb;
      r  = rem_ff;
      qa = qacc_ff;
      tb = tsh_ff;
      for (int i = 0; i < FRONT_STEPS; i++) begin
         sh = {r, tb[47]};
         tb = {tb[46:0], 1'b0};
         if (sh >= {1'b0, per}) begin
            sh = sh - {1'b0, per};
            qa = {qa[14:0], 1'b1};
         end else begin
            qa = {qa[14:0], 1'b0};
         end
         r = sh[15:0];
      end
      rem_in  = r;
      qacc_in = qa;
      tsh_in  = tb;
      cnt_in  = cnt_ff + 3'd1;
      // Hold the quotient while it waits for the queue
      if (state_ff != FR_BUSY) begin
         rem_in  = rem_ff;
         qacc_in = qacc_ff;
         tsh_in  = tsh_ff;
      end
      if (accept) begin
         rem_in  = 16'd0;
         qacc_in = 16'd0;
         tsh_in  = {req_time_tick, 16'd0};
         cnt_in  = 3'd0;
      end
   end

   assign px = $signed({1'b0, len_ff}) * sine_of(idx_ff + 8'd64);
   assign py = $signed({1'b0, len_ff}) * sine_of(idx_ff);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Advance datapath
   always_ff @(posedge clock) begin
      tsh_ff  <= tsh_in;
      rem_ff  <= rem_in;
      qacc_ff <= qacc_in;
      if (accept) begin
         idx_ff <= req_heading[15:8];
         spd_ff <= req_speed_scale;
      end
      len_ff <= 29'(cfg.step_len * spd_ff);
      sx_ff  <= px[44:0];
      sy_ff  <= py[44:0];
   end

   always_comb begin
      push_entry.gphase = qacc_ff;
      push_entry.mode   = mode;
      push_entry.duty   = (mode == MODE_WAVE) ? WAVE_DUTY : cfg.duty_fraction;
      push_entry.lift   = (mode == MODE_WAVE) ? WAVE_LIFT : cfg.lift_height;
      push_entry.sx     = sx_ff;
      push_entry.sy     = sy_ff;
   end

endmodule

>>> rtl/hgft_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
module hgft_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  hgft_pkg::qent_type  push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output hgft_pkg::qent_type  head
);
   import hgft_pkg::*;

   qent_type   mem_ff [QUEUE_DEPTH];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign head       = mem_ff[rd_ff];

   // Track pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

>>> rtl/hgft_back.sv
// Back part: per-leg pipeline with divider, multipliers and saturation.
`timescale 1ns / 1ps
module hgft_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  hgft_pkg::qent_type  head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_leg_index,
   output logic signed [15:0]  rsp_foot_x,
   output logic signed [15:0]  rsp_foot_y,
   output logic signed [15:0]  rsp_foot_z,
   output logic                rsp_in_swing,
   output logic                rsp_last_leg
);
   import hgft_pkg::*;

   function automatic logic signed [15:0] round_sat(input logic signed [63:0] v,
                                                    input logic signed [15:0] base);
      logic [63:0] m;
      logic signed [21:0] s;
      m = v[63] ? 64'(-v) : 64'(v);
      m = m + (64'd1 << 43);
      s = v[63] ? -$signed({2'b00, m[63:44]}) : $signed({2'b00, m[63:44]});
      s = s + 22'(base);
      if (s > 22'sd32767) return 16'sh7fff;
      if (s < -22'sd32768) return 16'sh8000;
      return s[15:0];
   endfunction

   logic        adv;
   logic [2:0]  leg_ff;
   logic [15:0] lp;
   logic        swing;

   // Divider stages
   logic        dv_ff  [DIV_STEPS+1];
   leg_pl_type  dpl_ff [DIV_STEPS+1];
   logic [16:0] drem_ff[DIV_STEPS+1];
   logic [16:0] dd_ff  [DIV_STEPS+1];
   logic [15:0] dq_ff  [DIV_STEPS+1];
   logic [16:0] drem_in[DIV_STEPS];
   logic        dbit   [DIV_STEPS];

   // Multiply stages
   logic        p1v_ff, p2v_ff, p3v_ff;
   leg_pl_type  p1pl_ff, p2pl_ff, p3pl_ff;
   logic signed [40:0] pxh_ff, pxl_ff, pyh_ff, pyl_ff;
   logic [30:0] dsq_ff;
   logic signed [63:0] px_ff, py_ff;
   logic [32:0] g_ff;
   logic [45:0] lg_ff;
   logic signed [15:0] x3_ff, y3_ff;

   logic signed [17:0] f;
   logic signed [35:0] fsq;
   logic signed [22:0] sxh, sxl, syh, syl;
   logic [46:0] zsum;

   assign adv = !rsp_valid || rsp_ready;
   assign pop = adv && head_valid && (leg_ff == LEG_LAST);
   assign lp  = head.gphase + leg_phase(head.mode, leg_ff);
   assign swing = !(lp < head.duty);

   // One restoring step per stage
   always_comb begin
      logic [17:0] sh;
      for (int i = 0; i < DIV_STEPS; i++) begin
         sh = {drem_ff[i], 1'b0};
         dbit[i] = (sh >= {1'b0, dd_ff[i]});
         drem_in[i] = dbit[i] ? 17'(sh - {1'b0, dd_ff[i]}) : sh[16:0];
      end
   end

   // Stance and swing position to signed stride factor
   always_comb begin
      if (dpl_ff[DIV_STEPS].swing)
         f = $signed({2'b00, dq_ff[DIV_STEPS]}) - 18'sd32768;
      else
         f = 18'sd32768 - $signed({2'b00, dq_ff[DIV_STEPS]});
      fsq = f * f;
      sxh = dpl_ff[DIV_STEPS].sx[44:22];
      sxl = $signed({1'b0, dpl_ff[DIV_STEPS].sx[21:0]});
      syh = dpl_ff[DIV_STEPS].sy[44:22];
      syl = $signed({1'b0, dpl_ff[DIV_STEPS].sy[21:0]});
   end

   assign zsum = {1'b0, lg_ff} + (47'd1 << 31);

   // Step through legs of the head request
   always_ff @(posedge clock) begin
      if (reset) begin
         leg_ff <= 3'd0;
      end else if (adv && head_valid) begin
         leg_ff <= (leg_ff == LEG_LAST) ? 3'd0 : leg_ff + 3'd1;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) dv_ff[i] <= 1'b0;
         p1v_ff    <= 1'b0;
         p2v_ff    <= 1'b0;
         p3v_ff    <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= head_valid;
         for (int i = 0; i < DIV_STEPS; i++) dv_ff[i+1] <= dv_ff[i];
         p1v_ff    <= dv_ff[DIV_STEPS];
         p2v_ff    <= p1v_ff;
         p3v_ff    <= p2v_ff;
         rsp_valid <= p3v_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         dpl_ff[0].leg   <= leg_ff;
         dpl_ff[0].last  <= (leg_ff == LEG_LAST);
         dpl_ff[0].swing <= swing;
         dpl_ff[0].lift  <= head.lift;
         dpl_ff[0].sx    <= head.sx;
         dpl_ff[0].sy    <= head.sy;
         drem_ff[0] <= swing ? {1'b0, 16'(lp - head.duty)} : {1'b0, lp};
         dd_ff[0]   <= swing ? 17'(17'h10000 - {1'b0, head.duty}) : {1'b0, head.duty};
         dq_ff[0]   <= 16'd0;
         for (int i = 0; i < DIV_STEPS; i++) begin
            dpl_ff[i+1]  <= dpl_ff[i];
            drem_ff[i+1] <= drem_in[i];
            dd_ff[i+1]   <= dd_ff[i];
            dq_ff[i+1]   <= {dq_ff[i][14:0], dbit[i]};
         end
         // partial products
         p1pl_ff <= dpl_ff[DIV_STEPS];
         pxh_ff  <= sxh * f;
         pxl_ff  <= sxl * f;
         pyh_ff  <= syh * f;
         pyl_ff  <= syl * f;
         dsq_ff  <= fsq[30:0];
         // sums and lift factor
         p2pl_ff <= p1pl_ff;
         px_ff   <= (64'(pxh_ff) <<< 22) + 64'(pxl_ff);
         py_ff   <= (64'(pyh_ff) <<< 22) + 64'(pyl_ff);
         g_ff    <= 33'(33'h1_0000_0000 - {dsq_ff, 2'b00});
         // round, lift product
         p3pl_ff <= p2pl_ff;
         x3_ff   <= round_sat(px_ff, stand_x(p2pl_ff.leg));
         y3_ff   <= round_sat(py_ff, stand_y(p2pl_ff.leg));
         lg_ff   <= 46'(p2pl_ff.lift * g_ff);
         // result register
         rsp_leg_index <= p3pl_ff.leg;
         rsp_last_leg  <= p3pl_ff.last;
         rsp_in_swing  <= p3pl_ff.swing;
         rsp_foot_x    <= x3_ff;
         rsp_foot_y    <= y3_ff;
         rsp_foot_z    <= p3pl_ff.swing ? STAND_Z + $signed({1'b0, zsum[46:32]}) : STAND_Z;
      end
   end

endmodule

>>> rtl/hexapod_gait_foot_trajectory_core.sv
// Top level: registers, front part, queue and back part of the gait core.
//
//  channel | ports                                   | role
//  req     | req_valid/ready, time_tick, heading, ... | request in
//  rsp     | rsp_valid/ready, leg_index, foot_x/y/z   | six leg results per request
//  csr     | csr_valid/ready, csr_index, csr_wdata    | register writes
//
// The front part works through 48 restoring steps of the phase division, eight per
// cycle, then hands the result to the queue.
// The back part emits one leg per cycle while rsp_ready is high, 6 per request.
// Reset is synchronous and clears the registers to their defaults and all valid state.
// A stall on rsp freezes the back pipeline; the queue lets the front keep working until it fills.
`timescale 1ns / 1ps
module hexapod_gait_foot_trajectory_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_tick,
   input  logic [15:0]        req_heading,
   input  logic [15:0]        req_speed_scale,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_leg_index,
   output logic signed [15:0] rsp_foot_x,
   output logic signed [15:0] rsp_foot_y,
   output logic signed [15:0] rsp_foot_z,
   output logic               rsp_in_swing,
   output logic               rsp_last_leg,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import hgft_pkg::*;
   `include "assert_macros.svh"

   cfg_type  cfg_ff;
   logic     push_valid, push_ready, head_valid, pop;
   qent_type push_entry, head;

   assign csr_ready = 1'b1;

   // Write registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gait_mode     <= MODE_TRIPOD;
         cfg_ff.cycle_period  <= 16'd1000;
         cfg_ff.duty_fraction <= 16'd32768;
         cfg_ff.step_len      <= 13'd800;
         cfg_ff.lift_height   <= 13'd480;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIT_MODE: cfg_ff.gait_mode     <= csr_wdata[1:0];
            CSR_PERIOD:    cfg_ff.cycle_period  <= csr_wdata;
            CSR_DUTY:      cfg_ff.duty_fraction <= csr_wdata;
            CSR_STRIDE:    cfg_ff.step_len      <= csr_wdata[12:0];
            CSR_LIFT:      cfg_ff.lift_height   <= csr_wdata[12:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   hgft_front u_front (
      .clock, .reset, .cfg(cfg_ff),
      .req_valid, .req_ready, .req_time_tick, .req_heading, .req_speed_scale,
      .push_valid, .push_ready, .push_entry
   );

   hgft_queue u_queue (
      .clock, .reset, .push_valid, .push_ready, .push_entry,
      .pop_valid(head_valid), .pop, .head
   );

   hgft_back u_back (
      .clock, .reset, .head_valid, .head, .pop,
      .rsp_valid, .rsp_ready, .rsp_leg_index, .rsp_foot_x, .rsp_foot_y,
      .rsp_foot_z, .rsp_in_swing, .rsp_last_leg
   );

   `HGFT_ASSERT_IMP(a_last_leg, rsp_valid && rsp_last_leg, rsp_leg_index == LEG_LAST, "last off")
   `HGFT_ASSERT_IMP(a_stance_z, rsp_valid && !rsp_in_swing, rsp_foot_z == STAND_Z, "stance lifted")
   `HGFT_ASSERT_IMP(a_pop_valid, pop, head_valid, "pop from empty queue")

endmodule

>>> verif/hexapod_gait_foot_trajectory_core_tb.sv
// Self-checking testbench of the hexapod gait foot trajectory core.
`timescale 1ns / 1ps
module hexapod_gait_foot_trajectory_core_tb;
   import hgft_pkg::*;

   typedef struct {
      logic [2:0]         leg;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic signed [15:0] fz;
      logic               swing;
      logic               last;
   } foot_target_type;

   localparam int QSINE [65] = '{
      0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370, 4756,
      5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765, 9102,
      9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866, 12140, 12406,
      12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256, 14449, 14635,
      14811, 14978, 15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
      16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384};
   localparam int LEG_OFFSET [3][6] = '{
      '{0, 32768, 0, 32768, 0, 32768},
      '{0, 32768, 13107, 45875, 26214, 58982},
      '{0, 32768, 21627, 54395, 43909, 11141}};
   localparam int HOME_X [6] = '{1600, 0, -1600, 1600, 0, -1600};
   localparam int HOME_Y [6] = '{1600, 1920, 1600, -1600, -1920, -1600};
   localparam int DRAIN_CYCLES = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_time_tick = '0;
   logic [15:0]        req_heading = '0;
   logic [15:0]        req_speed_scale = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_leg_index;
   logic signed [15:0] rsp_foot_x;
   logic signed [15:0] rsp_foot_y;
   logic signed [15:0] rsp_foot_z;
   logic               rsp_in_swing;
   logic               rsp_last_leg;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   // Shadow copy of the registers
   logic [1:0]  sh_mode;
   logic [15:0] sh_period;
   logic [15:0] sh_duty;
   logic [12:0] sh_stride;
   logic [12:0] sh_lift;

   foot_target_type foot_target_q[$];
   int  error_count = 0;
   int  request_count = 0;
   int  leg_count = 0;
   bit  idle_on = 1'b1;
   bit  long_hold_req = 1'b0;
   int  hold_left = 0;
   int  stall_left = 0;

   hexapod_gait_foot_trajectory_core u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Full-wave sine, Q2.14, from an 8-bit angle
   function automatic longint sine_lookup(input int idx);
      int k;
      int v;
      k = idx & 63;
      v = ((idx >> 6) & 1) ? QSINE[64 - k] : QSINE[k];
      return ((idx >> 7) & 1) ? -v : v;
   endfunction

   function automatic longint round_off44(input longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << 43)) >>> 44;
      return (v < 0) ? -m : m;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   // Work out the six foot targets of one request
   task automatic predict_feet(input logic [31:0] t, input logic [15:0] hd,
                               input logic [15:0] spd);
      int               mode;
      longint unsigned  per;
      longint unsigned  duty;
      longint unsigned  lift;
      longint unsigned  gph;
      longint unsigned  lp;
      longint unsigned  g;
      longint           len;
      longint           sx;
      longint           sy;
      longint           f;
      longint           z;
      longint           w;
      longint           d;
      foot_target_type  ft;
      mode = (sh_mode > 2) ? 0 : sh_mode;
      per  = (sh_period == 0) ? 1 : sh_period;
      duty = (mode == 1) ? 55706 : sh_duty;
      lift = (mode == 1) ? 640 : sh_lift;
      gph  = ((longint'(t) % per) << 16) / per;
      len  = longint'(sh_stride) * longint'(spd);
      sx   = len * sine_lookup((hd[15:8] + 64) & 255);
      sy   = len * sine_lookup(hd[15:8]);
      for (int leg = 0; leg < LEG_COUNT; leg++) begin
         lp = (gph + LEG_OFFSET[mode][leg]) & 16'hFFFF;
         z  = -1600;
         ft.swing = !(lp < duty);
         if (!ft.swing) begin
            f = 32768 - longint'((lp << 16) / duty);
         end else begin
            w = (lp - duty) * 65536 / (65536 - duty);
            d = w - 32768;
            g = (longint'(1) << 32) - 4 * d * d;
            f = d;
            z = z + longint'((lift * g + (longint'(1) << 31)) >> 32);
         end
         ft.leg  = 3'(leg);
         ft.fx   = clamp16(HOME_X[leg] + round_off44(sx * f));
         ft.fy   = clamp16(HOME_Y[leg] + round_off44(sy * f));
         ft.fz   = clamp16(z);
         ft.last = (leg == LEG_COUNT - 1);
         foot_target_q.push_back(ft);
      end
   endtask

   // Send one request; caller stands at a rising edge
   task automatic send_request(input logic [31:0] t, input logic [15:0] hd,
                               input logic [15:0] spd);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_time_tick   <= t;
      req_heading     <= hd;
      req_speed_scale <= spd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_feet(t, hd, spd);
      request_count++;
   endtask

   // Wait until every expected leg has come out, then let the pipe drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (foot_target_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GAIT_MODE: sh_mode   = val[1:0];
         CSR_PERIOD:    sh_period = val;
         CSR_DUTY:      sh_duty   = val;
         CSR_STRIDE:    sh_stride = val[12:0];
         CSR_LIFT:      sh_lift   = val[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [1:0] m, input logic [15:0] p, input logic [15:0] d,
                            input logic [15:0] s, input logic [15:0] l);
      write_csr(CSR_GAIT_MODE, {14'($urandom), m});
      write_csr(CSR_PERIOD, p);
      write_csr(CSR_DUTY, d);
      write_csr(CSR_STRIDE, s);
      write_csr(CSR_LIFT, l);
   endtask

   task automatic send_random();
      logic [15:0] spd;
      spd = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
      send_request($urandom, 16'($urandom), spd);
   endtask

   // Extremes of the fields under reset values
   task automatic test_reset_defaults();
      send_request(32'd0, 16'd0, 16'd16384);
      send_request(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      send_request(32'd500, 16'h4000, 16'd0);
      send_request(32'd999, 16'h8000, 16'hFFFF);
      send_request(32'd250, 16'hC0FF, 16'd8192);
      wait_idle();
   endtask

   // Each gait mode, the unused mode, zero period, zero and full duty
   task automatic test_modes();
      for (int m = 0; m < 4; m++) begin
         write_all(2'(m), 16'd1000, 16'd40000, 16'h1FFF, 16'h1FFF);
         send_request(32'd123, 16'h2000, 16'hFFFF);
         send_request(32'd777, 16'hA000, 16'd16384);
         wait_idle();
      end
      write_all(MODE_TRIPOD, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(32'hDEAD_BEEF, 16'h1234, 16'hFFFF);
      send_request(32'd0, 16'h0000, 16'h0000);
      wait_idle();
      write_all(MODE_RIPPLE, 16'hFFFF, 16'hFFFF, 16'h1FFF, 16'h1FFF);
      send_request(32'hFFFF_FFFE, 16'h7F00, 16'hFFFF);
      send_request(32'd65534, 16'hFF00, 16'hFFFF);
      wait_idle();
      write_all(MODE_TRIPOD, 16'd1, 16'd1, 16'h1FFF, 16'h1FFF);
      send_request(32'd5, 16'h3000, 16'hFFFF);
      wait_idle();
      // Drop writes to register indexes past the last one
      write_csr(3'd5, 16'hFFFF);
      write_csr(3'd7, 16'h0000);
      send_request(32'd17, 16'h5500, 16'h7FFF);
      wait_idle();
   endtask

   // Random requests over a series of random settings
   task automatic test_random_settings(input int phases, input int per_phase);
      logic [15:0] p;
      logic [15:0] d;
      for (int ph = 0; ph < phases; ph++) begin
         case ($urandom_range(0, 3))
            0: p = 16'd0;
            1: p = 16'hFFFF;
            default: p = 16'($urandom_range(1, 5000));
         endcase
         case ($urandom_range(0, 4))
            0: d = 16'd0;
            1: d = 16'hFFFF;
            2: d = 16'd1;
            default: d = 16'($urandom);
         endcase
         write_all(2'($urandom), p, d, 16'($urandom), 16'($urandom));
         repeat (per_phase) send_random();
         wait_idle();
      end
   endtask

   // Hold the receiver off for a long stretch so the input stalls
   task automatic test_backpressure();
      long_hold_req = 1'b1;
      repeat (30) send_random();
      wait_idle();
   endtask

   // Receiver: random stalls and a long hold-off on demand
   always @(posedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each leg result with the oldest expectation
   always @(posedge clock) begin
      foot_target_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (foot_target_q.size() == 0) begin
            $display("%0t: unexpected leg result, leg %0d", $realtime, rsp_leg_index);
            error_count++;
         end else begin
            e = foot_target_q.pop_front();
            leg_count++;
            if (rsp_leg_index !== e.leg || rsp_foot_x !== e.fx || rsp_foot_y !== e.fy ||
                rsp_foot_z !== e.fz || rsp_in_swing !== e.swing ||
                rsp_last_leg !== e.last) begin
               $display("%0t: mismatch exp leg %0d x %0d y %0d z %0d sw %0b last %0b",
                        $realtime, e.leg, e.fx, e.fy, e.fz, e.swing, e.last);
               $display("%0t:          got leg %0d x %0d y %0d z %0d sw %0b last %0b",
                        $realtime, rsp_leg_index, rsp_foot_x, rsp_foot_y, rsp_foot_z,
                        rsp_in_swing, rsp_last_leg);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sh_mode   = MODE_TRIPOD;
      sh_period = 16'd1000;
      sh_duty   = 16'd32768;
      sh_stride = 13'd800;
      sh_lift   = 13'd480;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      test_reset_defaults();
      test_modes();
      test_random_settings(5, 70);
      test_backpressure();
      idle_on = 1'b0;
      test_random_settings(1, 40);
      if (foot_target_q.size() != 0) begin
         $display("%0t: %0d expected legs never came", $realtime, foot_target_q.size());
         error_count++;
      end
      $display("Sent %0d requests over all gait modes and register extremes,", request_count);
      $display("checked %0d leg results, %0d errors.", leg_count, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
